// ===== hdl/rfk_pkg.sv =====
// rfk_pkg: shared types and constants for the rectangle filter / top-k selector
// used by rfk_cell and rect_filter_top_k_by_rank; no dependencies
`default_nettype none

package rfk_pkg;

  // default list depth, legal range 1 to 64
  localparam int unsigned KEEP_COUNT_DEF = 20;

  // configuration port
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] REG_RECT_LOW_X  = 2'd0;
  localparam logic [1:0] REG_RECT_HIGH_X = 2'd1;
  localparam logic [1:0] REG_RECT_LOW_Y  = 2'd2;
  localparam logic [1:0] REG_RECT_HIGH_Y = 2'd3;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [30:0]        point_rank;
    logic [7:0]         point_id;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic [30:0]        hit_rank;
    logic [7:0]         hit_id;
    logic               no_hits;
    logic               last_hit;
  } hit_t;

  // one held list entry
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [30:0] rank;
    logic [7:0]  id;
  } held_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert the broadcast point
    logic pop;  // shift the list toward the head
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/rfk_cell.sv =====
// rfk_cell: one slot of the sorted top-k list
// depends on rfk_pkg; chained by rect_filter_top_k_by_rank
`default_nettype none

module rfk_cell
  import rfk_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cell_ctl_t ctl_i,
  input  wire held_t     new_i,
  input  wire held_t     prev_i,
  input  wire logic      prev_valid_i,
  input  wire logic      prev_gt_i,
  input  wire held_t     next_i,
  input  wire logic      next_valid_i,
  output logic           valid_o,
  output held_t          entry_o,
  output logic           gt_o
);

  logic  valid_q, valid_d;
  held_t entry_q, entry_d;

  // new point belongs at or before this slot
  assign gt_o = !valid_q || (new_i.rank < entry_q.rank);

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctl_i.pop) begin
      valid_d = next_valid_i;
      entry_d = next_i;
    end else if (ctl_i.ins && gt_o) begin
      // first slot that is greater takes the point, the rest shift down
      valid_d = prev_gt_i ? prev_valid_i : 1'b1;
      entry_d = prev_gt_i ? prev_i : new_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== hdl/rect_filter_top_k_by_rank.sv =====
// rect_filter_top_k_by_rank: rectangle filter feeding a sorted top-k chain of cells
// depends on rfk_pkg and rfk_cell
// ordinary points: one request per cycle while idle, the chain compares and shifts on accept
// last point: its accept moves the sequencer to drain, then the list drains one result per
//   cycle through the output register while out is not stalled; input stalls while draining
// reset: list empty, rectangle bounds zero, no result pending
`default_nettype none

module rect_filter_top_k_by_rank
  import rfk_pkg::*;
#(
  parameter int unsigned KEEP_COUNT = KEEP_COUNT_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input requests
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire point_t            in_data_i,
  // result requests
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output hit_t                   out_data_o,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic signed [31:0] low_x_q, high_x_q, low_y_q, high_y_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_x_q  <= '0;
      high_x_q <= '0;
      low_y_q  <= '0;
      high_y_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_RECT_LOW_X:  low_x_q  <= pwdata;
        REG_RECT_HIGH_X: high_x_q <= pwdata;
        REG_RECT_LOW_Y:  low_y_q  <= pwdata;
        REG_RECT_HIGH_Y: high_y_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RECT_LOW_X:  prdata = low_x_q;
      REG_RECT_HIGH_X: prdata = high_x_q;
      REG_RECT_LOW_Y:  prdata = low_y_q;
      REG_RECT_HIGH_Y: prdata = high_y_q;
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // input side and rectangle test
  // ---------------------------------------------------------------
  state_e state_q, state_d;
  logic   in_acc;
  logic   in_rect;
  held_t  new_pt;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // inclusive bounds, signed compare
  assign in_rect = ($signed(in_data_i.point_x) >= low_x_q) &&
                   ($signed(in_data_i.point_x) <= high_x_q) &&
                   ($signed(in_data_i.point_y) >= low_y_q) &&
                   ($signed(in_data_i.point_y) <= high_y_q);

  assign new_pt.x    = in_data_i.point_x;
  assign new_pt.y    = in_data_i.point_y;
  assign new_pt.rank = in_data_i.point_rank;
  assign new_pt.id   = in_data_i.point_id;

  // ---------------------------------------------------------------
  // chain of cells, head at index 0
  // ---------------------------------------------------------------
  cell_ctl_t             ctl;
  logic [KEEP_COUNT-1:0] valid;
  logic [KEEP_COUNT-1:0] gt;
  held_t                 ent [KEEP_COUNT];
  logic                  out_free;
  logic                  empty_q, empty_d;
  logic                  second_valid;

  for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
    held_t prev_ent, next_ent;
    logic  prev_valid, prev_gt, next_valid;

    if (i == 0) begin : g_head
      assign prev_ent   = new_pt;
      assign prev_valid = 1'b0;
      assign prev_gt    = 1'b0;
    end else begin : g_mid
      assign prev_ent   = ent[i-1];
      assign prev_valid = valid[i-1];
      assign prev_gt    = gt[i-1];
    end

    if (i == KEEP_COUNT - 1) begin : g_tail
      // worst entry falls off the end on insert into a full list
      assign next_ent   = ent[i];
      assign next_valid = 1'b0;
    end else begin : g_body
      assign next_ent   = ent[i+1];
      assign next_valid = valid[i+1];
    end

    rfk_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .new_i        (new_pt),
      .prev_i       (prev_ent),
      .prev_valid_i (prev_valid),
      .prev_gt_i    (prev_gt),
      .next_i       (next_ent),
      .next_valid_i (next_valid),
      .valid_o      (valid[i]),
      .entry_o      (ent[i]),
      .gt_o         (gt[i])
    );
  end

  if (KEEP_COUNT > 1) begin : g_second
    assign second_valid = valid[1];
  end else begin : g_single
    assign second_valid = 1'b0;
  end

  // ---------------------------------------------------------------
  // sequencer: idle accepts points, drain empties the list
  // ---------------------------------------------------------------
  logic out_valid_q, out_valid_d;
  hit_t out_q, out_d;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    empty_d     = empty_q;
    ctl.ins     = 1'b0;
    ctl.pop     = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        ctl.ins = in_acc && in_rect;
        if (in_acc && in_data_i.last_point) begin
          // list holds nothing after this point goes in
          empty_d = !(valid[0] || in_rect);
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (empty_q) begin
            out_d   = '0;
            out_d.no_hits  = 1'b1;
            out_d.last_hit = 1'b1;
            state_d = ST_IDLE;
          end else begin
            ctl.pop        = 1'b1;
            out_d.hit_x    = ent[0].x;
            out_d.hit_y    = ent[0].y;
            out_d.hit_rank = ent[0].rank;
            out_d.hit_id   = ent[0].id;
            out_d.no_hits  = 1'b0;
            out_d.last_hit = !second_valid;
            if (!second_valid) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  // held entries always form a contiguous run from the head
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid + 1'b1) & valid) == '0)
    else $error("held list has a gap");

  // an empty-marked drain never sees a held entry
  a_empty_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && empty_q) |-> !valid[0])
    else $error("empty drain with held entries");

  // a final point always starts a drain
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.last_point) |=> (state_q == ST_DRAIN))
    else $error("last point did not start drain");

  // list is empty whenever a drain has finished
  a_drain_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && state_d == ST_IDLE) |=> (valid == '0))
    else $error("list not cleared after drain");

endmodule

`default_nettype wire
